>>> design/sbp_pkg.sv
// Shared types, register codes and the sine level table for the breathing LED PWM driver.
package sbp_pkg;

  typedef logic [7:0] level_t;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WAVE_STEP = 2'd0,
    REG_PHASE     = 2'd1
  } cfg_reg_t;

  // Register reset values
  localparam level_t WAVE_STEP_RESET = 8'd6;
  localparam level_t PHASE_RESET     = 8'd85;

  // Tick counter ceiling and the number of LED drive outputs
  localparam level_t      TICKS_MAX     = 8'd255;
  localparam int unsigned LEDS_REPORTED = 3;

  // One full period of an offset sine, 0..255
  localparam level_t SINE_TABLE [256] = '{
    8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
    8'd152, 8'd156, 8'd159, 8'd162, 8'd165, 8'd168, 8'd171, 8'd174,
    8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd191, 8'd193, 8'd196,
    8'd199, 8'd201, 8'd204, 8'd206, 8'd209, 8'd211, 8'd213, 8'd216,
    8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
    8'd234, 8'd236, 8'd237, 8'd239, 8'd240, 8'd242, 8'd243, 8'd245,
    8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd252, 8'd252,
    8'd253, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254,
    8'd253, 8'd252, 8'd252, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247,
    8'd246, 8'd245, 8'd243, 8'd242, 8'd240, 8'd239, 8'd237, 8'd236,
    8'd234, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd220,
    8'd218, 8'd216, 8'd213, 8'd211, 8'd209, 8'd206, 8'd204, 8'd201,
    8'd199, 8'd196, 8'd193, 8'd191, 8'd188, 8'd185, 8'd182, 8'd179,
    8'd176, 8'd174, 8'd171, 8'd168, 8'd165, 8'd162, 8'd159, 8'd156,
    8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134, 8'd131,
    8'd128, 8'd124, 8'd121, 8'd118, 8'd115, 8'd112, 8'd109, 8'd106,
    8'd103, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,  8'd81,
    8'd79,  8'd76,  8'd73,  8'd70,  8'd67,  8'd64,  8'd62,  8'd59,
    8'd56,  8'd54,  8'd51,  8'd49,  8'd46,  8'd44,  8'd42,  8'd39,
    8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,
    8'd21,  8'd19,  8'd18,  8'd16,  8'd15,  8'd13,  8'd12,  8'd10,
    8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd3,   8'd3,
    8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,
    8'd2,   8'd3,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,
    8'd9,   8'd10,  8'd12,  8'd13,  8'd15,  8'd16,  8'd18,  8'd19,
    8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
    8'd37,  8'd39,  8'd42,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,
    8'd56,  8'd59,  8'd62,  8'd64,  8'd67,  8'd70,  8'd73,  8'd76,
    8'd79,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,
    8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124
  };

endpackage

>>> design/sbp_level_lut.sv
// Per-channel sine level lookup at the wave position plus each channel's phase offset.
module sbp_level_lut #(
  parameter int unsigned CHANNELS = 3
) (
  input  sbp_pkg::level_t wave,
  input  sbp_pkg::level_t phase,
  output sbp_pkg::level_t levels [CHANNELS]
);
  import sbp_pkg::*;

  // Table position per channel wraps mod 256 by truncation
  for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
    level_t pos;
    assign pos       = wave + level_t'(level_t'(g) * phase);
    assign levels[g] = SINE_TABLE[pos];
  end

endmodule

>>> design/sine_breathing_pwm_leds.sv
// Breathing LED PWM driver: three sine-modulated channels with a registered result word.
// Each accepted tick word's result word is registered and is presented in the next cycle.
// One word per cycle while out_ready is high; the register refills on the cycle it drains.
// The critical path runs through the wave adder, the sine lookup and the slot compare.
// Reset (synchronous, active high) clears the counters and the wave position, restores
// step 6 and phase 85, loads the channel levels of position zero and empties the output.
module sine_breathing_pwm_leds #(
  parameter int unsigned WINDOW_TICKS = 8,
  parameter int unsigned CHANNELS     = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  // tick channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                advance,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                led_green_on,
  output logic                                led_yellow_on,
  output logic                                led_red_on,
  output logic [7:0]                          wave_index,
  // configuration writes
  input  logic                                cfg_write_en,
  input  logic [sbp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sbp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import sbp_pkg::*;

  // Registers
  level_t     wave_step_ticks;
  level_t     phase_spacing;
  logic [3:0] window_ticks_done;
  level_t     ticks_since_step;
  level_t     wave_position;
  level_t     level [CHANNELS];

  // Next values
  logic [3:0] window_ticks_done_next;
  level_t     ticks_since_step_next;
  level_t     wave_position_next;
  level_t     level_next [CHANNELS];
  level_t     lut_levels [CHANNELS];
  level_t     ticks_inc;
  level_t     slot_next;
  level_t     slot_lut [16];
  logic [LEDS_REPORTED-1:0] lit_next;
  logic       new_window;
  logic       in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_step_ticks <= WAVE_STEP_RESET;
      phase_spacing   <= PHASE_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_WAVE_STEP: wave_step_ticks <= cfg_wdata;
        REG_PHASE:     phase_spacing   <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // Tick bookkeeping: window counter, saturating step counter, wave advance
  always_comb begin
    ticks_inc              = (ticks_since_step == TICKS_MAX) ? ticks_since_step
                                                             : ticks_since_step + 8'd1;
    new_window             = advance && (32'(window_ticks_done) >= WINDOW_TICKS);
    window_ticks_done_next = window_ticks_done;
    ticks_since_step_next  = ticks_since_step;
    wave_position_next     = wave_position;
    if (advance) begin
      ticks_since_step_next = ticks_inc;
      if (new_window) begin
        window_ticks_done_next = 4'd0;
        if (ticks_inc >= wave_step_ticks) begin
          wave_position_next    = wave_position + 8'd1;
          ticks_since_step_next = 8'd0;
        end
      end else begin
        window_ticks_done_next = window_ticks_done + 4'd1;
      end
    end
  end

  // Sine levels at the new wave position, latched only at a window start
  sbp_level_lut #(
    .CHANNELS (CHANNELS)
  ) u_lut (
    .wave   (wave_position_next),
    .phase  (phase_spacing),
    .levels (lut_levels)
  );

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      level_next[c] = new_window ? lut_levels[c] : level[c];
    end
  end

  // PWM slot per window count, elapsed*255/WINDOW_TICKS clamped at 255, fixed at elaboration
  for (genvar g = 0; g < 16; g++) begin : g_slot
    localparam int unsigned SLOT = (g * 255) / WINDOW_TICKS;
    assign slot_lut[g] = (SLOT > 255) ? 8'd255 : level_t'(SLOT);
  end

  assign slot_next = slot_lut[window_ticks_done_next];

  // Drive compare; channels that are not built stay dark
  for (genvar g = 0; g < LEDS_REPORTED; g++) begin : g_lit
    if (g < CHANNELS) begin : g_on
      assign lit_next[g] = slot_next < level_next[g];
    end else begin : g_off
      assign lit_next[g] = 1'b0;
    end
  end

  // State update on an accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks_done <= 4'd0;
      ticks_since_step  <= 8'd0;
      wave_position     <= 8'd0;
      for (int c = 0; c < CHANNELS; c++) begin
        level[c] <= SINE_TABLE[level_t'(level_t'(c) * PHASE_RESET)];
      end
    end else if (in_fire) begin
      window_ticks_done <= window_ticks_done_next;
      ticks_since_step  <= ticks_since_step_next;
      wave_position     <= wave_position_next;
      for (int c = 0; c < CHANNELS; c++) begin
        level[c] <= level_next[c];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      led_green_on  <= lit_next[0];
      led_yellow_on <= lit_next[1];
      led_red_on    <= lit_next[2];
      wave_index    <= wave_position_next;
    end
  end

  // Checks
  a_window_range: assert property (@(posedge clk) disable iff (rst)
    32'(window_ticks_done) <= WINDOW_TICKS)
    else $error("window counter past its end");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_fire && !advance |=> $stable(window_ticks_done) && $stable(wave_position)
                            && $stable(ticks_since_step))
    else $error("hold word changed state");

  a_wave_at_start: assert property (@(posedge clk) disable iff (rst)
    !$stable(wave_position) |-> window_ticks_done == 4'd0)
    else $error("wave moved outside a window start");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid && wave_index == wave_position)
    else $error("result word does not match the wave position");

endmodule

>>> tb/tb_sine_breathing_pwm_leds.sv
// Self-checking testbench for the breathing LED PWM driver: tick stimulus, predictor, scoreboard.
module tb_sine_breathing_pwm_leds;
  import sbp_pkg::*;

  localparam int unsigned WINDOW = 8;
  localparam int unsigned LEDS   = 3;

  // register indexes that the block does not implement
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic   green;
    logic   yellow;
    logic   red;
    level_t index;
  } led_word_t;

  // Predictor of the LED word and store of words still owed by the block
  class breath_scoreboard;
    level_t    step_ticks;
    level_t    phase_step;
    logic [3:0] elapsed;
    level_t    since_step;
    level_t    wave;
    level_t    level [LEDS];
    led_word_t owed_words [$];
    int        faults;

    function new();
      step_ticks = WAVE_STEP_RESET;
      phase_step = PHASE_RESET;
      elapsed    = '0;
      since_step = '0;
      wave       = '0;
      faults     = 0;
      latch_levels();
    endfunction

    function void latch_levels();
      level_t pos;
      for (int c = 0; c < LEDS; c++) begin
        pos      = wave + level_t'(c) * phase_step;
        level[c] = SINE_TABLE[pos];
      end
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, level_t value);
      case (idx)
        REG_WAVE_STEP: step_ticks = value;
        REG_PHASE:     phase_step = value;
        default:       ;  // unknown index: ignored
      endcase
    endfunction

    // accepted tick word: advance the state and note the LED word it yields
    function void note_tick(logic adv);
      int        slot;
      led_word_t w;
      if (adv) begin
        if (since_step != TICKS_MAX) since_step++;
        if (elapsed >= WINDOW) begin
          elapsed = '0;
          if (since_step >= step_ticks) begin
            wave++;
            since_step = '0;
          end
          latch_levels();
        end else begin
          elapsed++;
        end
      end
      slot     = (int'(elapsed) * 255) / WINDOW;
      w.green  = slot < int'(level[0]);
      w.yellow = slot < int'(level[1]);
      w.red    = slot < int'(level[2]);
      w.index  = wave;
      owed_words.push_back(w);
    endfunction

    function void check_word(led_word_t got);
      led_word_t want;
      if (owed_words.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected result word: g%0b y%0b r%0b wave %0d",
                   got.green, got.yellow, got.red, got.index);
        return;
      end
      want = owed_words.pop_front();
      if (got.green !== want.green || got.yellow !== want.yellow ||
          got.red !== want.red || got.index !== want.index) begin
        faults++;
        if (faults <= 10)
          $display("mismatch: expected g%0b y%0b r%0b wave %0d, got g%0b y%0b r%0b wave %0d",
                   want.green, want.yellow, want.red, want.index,
                   got.green, got.yellow, got.red, got.index);
      end
    endfunction

    function int pending();
      return owed_words.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   advance = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   led_green_on;
  logic                   led_yellow_on;
  logic                   led_red_on;
  logic [7:0]             wave_index;
  logic                   cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  breath_scoreboard sb;
  bit               idle_on = 1'b1;
  int               stall_left = 0;

  sine_breathing_pwm_leds #(
    .WINDOW_TICKS(WINDOW),
    .CHANNELS    (LEDS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .advance      (advance),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .led_green_on (led_green_on),
    .led_yellow_on(led_yellow_on),
    .led_red_on   (led_red_on),
    .wave_index   (wave_index),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (!idle_on || rst) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(99) < 25) stall_left = pick_gap();
    end
  end

  // sample handshakes and register writes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_word('{led_green_on, led_yellow_on, led_red_on, wave_index});
      if (in_valid && in_ready) sb.note_tick(advance);
      if (cfg_write_en) sb.write_reg(cfg_index, cfg_wdata);
    end
  end

  task automatic send_tick(logic adv);
    @(negedge clk);
    in_valid <= 1'b1;
    advance  <= adv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic hold_off(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // drop valid and wait for every owed word
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, level_t value);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_wdata    <= value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  initial begin
    level_t steps  [6];
    level_t phases [6];
    int     counts [6];
    int     holds  [6];
    int     gap;
    sb = new();
    steps  = '{8'd1, 8'd0, 8'd255, 8'd3, 8'd0, WAVE_STEP_RESET};
    phases = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd0, PHASE_RESET};
    counts = '{150, 150, 360, 120, 130, 140};
    holds  = '{15, 15, 3, 15, 15, 15};
    steps[4]  = level_t'($urandom_range(254, 1));
    phases[4] = level_t'($urandom_range(255));
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: holds, then two full windows at reset settings
    send_tick(1'b0);
    send_tick(1'b0);
    repeat (WINDOW + 1) send_tick(1'b1);
    send_tick(1'b0);
    repeat (WINDOW + 1) send_tick(1'b1);
    send_tick(1'b0);
    settle();
    // writes to unimplemented indexes must leave the settings alone
    write_reg(REG_SPARE_A, 8'hFF);
    write_reg(REG_SPARE_B, 8'h00);
    send_tick(1'b1);
    send_tick(1'b0);

    // random phases: fast step, zero step, saturating counter, no idling, random, defaults
    for (int p = 0; p < 6; p++) begin
      settle();
      write_reg(REG_WAVE_STEP, steps[p]);
      write_reg(REG_PHASE, phases[p]);
      if (p == 3) write_reg(REG_SPARE_B, level_t'($urandom_range(255)));
      idle_on = (p != 3);
      for (int n = 0; n < counts[p]; n++) begin
        send_tick($urandom_range(99) >= holds[p]);
        if (idle_on) begin
          gap = pick_gap();
          if (gap > 0) hold_off(gap);
        end
      end
    end
    settle();
    repeat (4) @(posedge clk);

    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("sine_breathing_pwm_leds test passed");
    end else begin
      $display("sine_breathing_pwm_leds test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("sine_breathing_pwm_leds test failed");
    $finish;
  end

endmodule
